// ===== rtl/smd_pkg.sv =====
// shared types and constants for the sorted merge with deletes unit
// no dependencies; imported by every module of the block

package smd_pkg;

  // id width default and fixed widths
  localparam int ID_WIDTH_DEF = 64;
  localparam int COUNT_W      = 33;
  localparam int SPAN_W       = 32;

  // configuration port
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 4;
  localparam logic REG_RANGE_BASE = 1'b0;  // register index, taken from paddr[3]

  // emit source codes
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_BASE = 2'd1;
  localparam logic [1:0] EMIT_UPD  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_UPD_DEL   = 3'd1;
  localparam logic [2:0] ERR_BELOW     = 3'd2;
  localparam logic [2:0] ERR_SPAN      = 3'd3;
  localparam logic [2:0] ERR_NOT_INCR  = 3'd4;

  // decision of one merge step
  typedef struct packed {
    logic       adv_base;
    logic       adv_upd;
    logic       adv_base_del;
    logic       adv_upd_del;
    logic [1:0] emit_from;
    logic       merge_done;
    logic [2:0] error_code;
    logic       commit;
  } smd_ctrl_t;

endpackage

// ===== rtl/smd_cfg_regs.sv =====
// apb-style configuration register holding range_base_id
// depends on smd_pkg

module smd_cfg_regs import smd_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [ID_WIDTH-1:0]   range_base
);

  logic [ID_WIDTH-1:0] range_base_r;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[CFG_ADDR_W-1] == REG_RANGE_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_base_r <= '0;
    end else if (wr_en) begin
      range_base_r <= cfg_pwdata[ID_WIDTH-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_RANGE_BASE) begin
      cfg_prdata = CFG_DATA_W'(range_base_r);
    end
  end

  assign range_base = range_base_r;

endmodule

// ===== rtl/smd_step.sv =====
// combinational decision logic for one merge step and the next statistics
// depends on smd_pkg

module smd_step import smd_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                base_valid,
  input  logic [ID_WIDTH-1:0] base_id,
  input  logic                upd_valid,
  input  logic [ID_WIDTH-1:0] upd_id,
  input  logic                base_del_valid,
  input  logic [ID_WIDTH-1:0] base_del_id,
  input  logic                upd_del_valid,
  input  logic [ID_WIDTH-1:0] upd_del_id,
  input  logic [ID_WIDTH-1:0] range_base,
  input  logic [COUNT_W-1:0]  count,
  input  logic [ID_WIDTH-1:0] first_id,
  input  logic [ID_WIDTH-1:0] last_id,
  output smd_ctrl_t           ctrl,
  output logic [ID_WIDTH-1:0] emit_id,
  output logic [COUNT_W-1:0]  count_nxt,
  output logic [ID_WIDTH-1:0] first_nxt,
  output logic [ID_WIDTH-1:0] last_nxt,
  output logic [ID_WIDTH-1:0] min_id,
  output logic [ID_WIDTH-1:0] max_id
);

  logic                done;
  logic                skip_bd;
  logic                skip_ud;
  logic                bdel_hit;
  logic                udel_hit;
  logic                take_b;
  logic                take_u;
  logic [ID_WIDTH-1:0] cand;
  logic [ID_WIDTH-1:0] diff;
  logic [2:0]          emit_err;

  always_comb begin
    done     = !base_valid && !upd_valid;
    skip_bd  = base_valid && base_del_valid && (base_del_id < base_id);
    skip_ud  = upd_valid && upd_del_valid && (upd_del_id < upd_id);
    bdel_hit = base_valid && base_del_valid && (base_del_id == base_id);
    udel_hit = upd_valid && upd_del_valid && (upd_del_id == upd_id);

    if (base_valid && upd_valid) begin
      take_b = base_id <= upd_id;
      take_u = upd_id <= base_id;
    end else begin
      take_b = base_valid;
      take_u = upd_valid;
    end
    cand = take_u ? upd_id : base_id;
    diff = cand - range_base;

    // below base, then span, then strict increase
    if (cand < range_base) begin
      emit_err = ERR_BELOW;
    end else if (|diff[ID_WIDTH-1:SPAN_W]) begin
      emit_err = ERR_SPAN;
    end else if ((count != '0) && (cand <= last_id)) begin
      emit_err = ERR_NOT_INCR;
    end else begin
      emit_err = ERR_OK;
    end

    ctrl            = '0;
    ctrl.merge_done = done;
    emit_id         = '0;
    if (done) begin
      // nothing to do
    end else if (skip_bd || skip_ud) begin
      ctrl.adv_base_del = skip_bd;
      ctrl.adv_upd_del  = skip_ud;
    end else if (bdel_hit) begin
      ctrl.adv_base = 1'b1;
    end else if (udel_hit) begin
      ctrl.error_code = ERR_UPD_DEL;
    end else if (emit_err != ERR_OK) begin
      ctrl.error_code = emit_err;
    end else begin
      ctrl.commit    = 1'b1;
      ctrl.adv_base  = take_b;
      ctrl.adv_upd   = take_u;
      ctrl.emit_from = take_u ? EMIT_UPD : EMIT_BASE;
      emit_id        = cand;
    end

    count_nxt = count;
    first_nxt = first_id;
    last_nxt  = last_id;
    if (ctrl.commit) begin
      count_nxt = count + COUNT_W'(1);
      last_nxt  = cand;
      if (count == '0) begin
        first_nxt = cand;
      end
    end
    min_id = (count_nxt != '0) ? first_nxt : '0;
    max_id = (count_nxt != '0) ? last_nxt : '0;
  end

endmodule

// ===== rtl/sorted_merge_with_deletes_unit.sv =====
// top level of the sorted merge with deletes unit
// depends on smd_pkg, smd_cfg_regs and smd_step

// usage
//   in_* carries one item per merge step: the four stream heads (valid, id).
//   out_* returns one result per item: advance flags, the emitted id, the
//   error code and the running count, first and last emitted id.
//   cfg_* is an apb-style port with range_base_id at byte address 0; write it
//   only while no item is in flight.
// timing
//   an accepted item is registered and decided in the next cycle; its result
//   moves into the result register, which drives out_*. one item per cycle
//   is sustained while out_tready is high; the step is one pass of compares
//   and one id-wide subtract between the input and result registers, and the
//   statistics are updated in the same cycle so a following item sees them.
// reset
//   rst_n (synchronous, active low) empties both stages and clears the count,
//   first and last id and range_base_id.
// stalls
//   with out_tready low the result register holds; the input register can
//   still take one item, after which in_tready drops until the result moves.

module sorted_merge_with_deletes_unit import smd_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF,
  localparam int IN_W    = 4 + 4 * ID_WIDTH,
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = 4 + ID_WIDTH + 1 + 3 + COUNT_W + 2 * ID_WIDTH,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // from bit 0: base_valid, base_id, upd_valid, upd_id, base_del_valid,
  // base_del_id, upd_del_valid, upd_del_id, zero fill
  input  logic [IN_TW-1:0]      in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // from bit 0: adv_base, adv_upd, adv_base_del, adv_upd_del, emit_id,
  // merge_done, error_code, out_count, out_min_id, out_max_id, zero fill
  output logic [OUT_TW-1:0]     out_tdata,
  // from bit 0: emit_from
  output logic [1:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // input stage
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [IN_W-1:0]     s1_data_r;

  // result stage
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_TW-1:0]   out_data_r;
  logic [1:0]          out_user_r;
  logic [2:0]          out_err_r;

  // merge statistics
  logic [COUNT_W-1:0]  count_r;
  logic [ID_WIDTH-1:0] first_r;
  logic [ID_WIDTH-1:0] last_r;
  logic [COUNT_W-1:0]  count_nxt;
  logic [ID_WIDTH-1:0] first_nxt;
  logic [ID_WIDTH-1:0] last_nxt;

  logic [ID_WIDTH-1:0] range_base;
  smd_ctrl_t           step_ctrl;
  logic [ID_WIDTH-1:0] emit_id;
  logic [ID_WIDTH-1:0] min_id;
  logic [ID_WIDTH-1:0] max_id;

  logic                adv_s;   // input stage moves into the result stage
  logic                in_acc;

  assign adv_s     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv_s;
  assign in_acc    = in_tvalid && in_tready;

  smd_cfg_regs #(
    .ID_WIDTH (ID_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .range_base  (range_base)
  );

  // field slices follow the in_tdata packing
  smd_step #(
    .ID_WIDTH (ID_WIDTH)
  ) u_step (
    .base_valid     (s1_data_r[0]),
    .base_id        (s1_data_r[ID_WIDTH:1]),
    .upd_valid      (s1_data_r[ID_WIDTH+1]),
    .upd_id         (s1_data_r[2*ID_WIDTH+1:ID_WIDTH+2]),
    .base_del_valid (s1_data_r[2*ID_WIDTH+2]),
    .base_del_id    (s1_data_r[3*ID_WIDTH+2:2*ID_WIDTH+3]),
    .upd_del_valid  (s1_data_r[3*ID_WIDTH+3]),
    .upd_del_id     (s1_data_r[4*ID_WIDTH+3:3*ID_WIDTH+4]),
    .range_base     (range_base),
    .count          (count_r),
    .first_id       (first_r),
    .last_id        (last_r),
    .ctrl           (step_ctrl),
    .emit_id        (emit_id),
    .count_nxt      (count_nxt),
    .first_nxt      (first_nxt),
    .last_nxt       (last_nxt),
    .min_id         (min_id),
    .max_id         (max_id)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv_s) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv_s) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      first_r     <= '0;
      last_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv_s) begin
        count_r <= count_nxt;
        first_r <= first_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata[IN_W-1:0];
    end
    if (adv_s) begin
      out_data_r <= OUT_TW'({max_id, min_id, count_nxt, step_ctrl.error_code,
                             step_ctrl.merge_done, emit_id, step_ctrl.adv_upd_del,
                             step_ctrl.adv_base_del, step_ctrl.adv_upd,
                             step_ctrl.adv_base});
      out_user_r <= step_ctrl.emit_from;
      out_err_r  <= step_ctrl.error_code;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // a result that emits a row never carries an error
  a_emit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_user_r != EMIT_NONE)) |-> (out_err_r == ERR_OK))
    else $error("emitted row carries an error code");

  // a committed step bumps the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_s && step_ctrl.commit) |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("count did not advance on a committed step");

  // statistics hold while no item moves into the result stage
  a_stats_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_s |=> ($stable(count_r) && $stable(first_r) && $stable(last_r)))
    else $error("statistics changed without a step");

  // an error step advances no stream
  a_err_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_s && (step_ctrl.error_code != ERR_OK)) |->
      !(step_ctrl.adv_base || step_ctrl.adv_upd ||
        step_ctrl.adv_base_del || step_ctrl.adv_upd_del))
    else $error("stream advanced on an error step");

endmodule

// ===== sim/smd_merge_checker.sv =====
`timescale 1ns / 100ps
// checker for the sorted merge with deletes unit: watches the item, result and apb
// channels, predicts each merge step and compares results field by field; uses smd_pkg

module smd_merge_checker import smd_pkg::*; #(
  parameter int ID_W     = ID_WIDTH_DEF,
  localparam int IN_W    = 4 + 4 * ID_W,
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = 4 + ID_W + 1 + 3 + COUNT_W + 2 * ID_W,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TW-1:0]      in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_TW-1:0]     out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fails,
  output int                    pending
);

  localparam logic [ID_W-1:0] SPAN_MAX = {{(ID_W-SPAN_W){1'b0}}, {SPAN_W{1'b1}}};
  localparam int REPORT_MAX = 20;

  // last declared field sits at bit 0, so the struct matches the bus layout
  typedef struct packed {
    logic [ID_W-1:0] upd_del_id;
    logic            upd_del_valid;
    logic [ID_W-1:0] base_del_id;
    logic            base_del_valid;
    logic [ID_W-1:0] upd_id;
    logic            upd_valid;
    logic [ID_W-1:0] base_id;
    logic            base_valid;
  } step_heads_t;

  typedef struct packed {
    logic [1:0]         emit_from;
    logic [ID_W-1:0]    max_id;
    logic [ID_W-1:0]    min_id;
    logic [COUNT_W-1:0] row_count;
    logic [2:0]         error_code;
    logic               merge_done;
    logic [ID_W-1:0]    emit_id;
    logic               adv_upd_del;
    logic               adv_base_del;
    logic               adv_upd;
    logic               adv_base;
  } step_result_t;

  logic [ID_W-1:0]    range_base;
  logic [COUNT_W-1:0] n_emitted;
  logic [ID_W-1:0]    first_id;
  logic [ID_W-1:0]    last_id;
  step_result_t       decisions_q[$];
  int                 n_fail = 0;
  int                 n_pending = 0;

  assign fails   = n_fail;
  assign pending = n_pending;

  function automatic void check_field(string name, logic [ID_W-1:0] exp_v,
                                      logic [ID_W-1:0] act_v);
    if (act_v !== exp_v) begin
      if (n_fail < REPORT_MAX)
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // one merge decision; updates the running statistics on a clean emit
  function automatic step_result_t merge_step(step_heads_t h);
    step_result_t r;
    logic skip_bd, skip_ud, take_b, take_u;
    logic [ID_W-1:0] cand;
    r = '0;
    if (!h.base_valid && !h.upd_valid) begin
      r.merge_done = 1'b1;
    end else begin
      skip_bd = h.base_valid && h.base_del_valid && (h.base_del_id < h.base_id);
      skip_ud = h.upd_valid && h.upd_del_valid && (h.upd_del_id < h.upd_id);
      if (skip_bd || skip_ud) begin
        r.adv_base_del = skip_bd;
        r.adv_upd_del  = skip_ud;
      end else if (h.base_valid && h.base_del_valid && h.base_del_id == h.base_id) begin
        r.adv_base = 1'b1;
      end else if (h.upd_valid && h.upd_del_valid && h.upd_del_id == h.upd_id) begin
        r.error_code = ERR_UPD_DEL;
      end else begin
        if (h.base_valid && h.upd_valid) begin
          take_b = h.base_id <= h.upd_id;
          take_u = h.upd_id <= h.base_id;
        end else begin
          take_b = h.base_valid;
          take_u = h.upd_valid;
        end
        cand = take_u ? h.upd_id : h.base_id;
        if (cand < range_base)
          r.error_code = ERR_BELOW;
        else if (cand - range_base > SPAN_MAX)
          r.error_code = ERR_SPAN;
        else if (n_emitted != 0 && cand <= last_id)
          r.error_code = ERR_NOT_INCR;
        if (r.error_code == ERR_OK) begin
          if (n_emitted == 0)
            first_id = cand;
          last_id   = cand;
          n_emitted = n_emitted + 1'b1;
          r.adv_base  = take_b;
          r.adv_upd   = take_u;
          r.emit_from = take_u ? EMIT_UPD : EMIT_BASE;
          r.emit_id   = cand;
        end
      end
    end
    r.row_count = n_emitted;
    r.min_id    = (n_emitted != 0) ? first_id : '0;
    r.max_id    = (n_emitted != 0) ? last_id : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t exp_r;
    step_result_t act_r;
    if (!rst_n) begin
      range_base = '0;
      n_emitted  = '0;
      first_id   = '0;
      last_id    = '0;
      decisions_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (decisions_q.size() == 0) begin
          $error("result item with no step waiting");
          n_fail++;
        end else begin
          exp_r = decisions_q.pop_front();
          act_r = {out_tuser, out_tdata[OUT_W-1:0]};
          check_field("adv_base", exp_r.adv_base, act_r.adv_base);
          check_field("adv_upd", exp_r.adv_upd, act_r.adv_upd);
          check_field("adv_base_del", exp_r.adv_base_del, act_r.adv_base_del);
          check_field("adv_upd_del", exp_r.adv_upd_del, act_r.adv_upd_del);
          check_field("emit_from", exp_r.emit_from, act_r.emit_from);
          check_field("emit_id", exp_r.emit_id, act_r.emit_id);
          check_field("merge_done", exp_r.merge_done, act_r.merge_done);
          check_field("error_code", exp_r.error_code, act_r.error_code);
          check_field("out_count", exp_r.row_count, act_r.row_count);
          check_field("out_min_id", exp_r.min_id, act_r.min_id);
          check_field("out_max_id", exp_r.max_id, act_r.max_id);
          check_field("zero fill", '0, out_tdata[OUT_TW-1:OUT_W]);
        end
      end
      // apb access phase
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[3] == REG_RANGE_BASE) begin
        if (cfg_pwrite)
          range_base = cfg_pwdata[ID_W-1:0];
        else
          check_field("range_base_id", range_base, cfg_prdata[ID_W-1:0]);
      end
      if (in_tvalid && in_tready)
        decisions_q.push_back(merge_step(step_heads_t'(in_tdata[IN_W-1:0])));
    end
    n_pending = decisions_q.size();
  end

endmodule

// ===== sim/tb_sorted_merge_with_deletes_unit.sv =====
`timescale 1ns / 100ps
// testbench top for the sorted merge with deletes unit: clock, reset, stimulus and verdict
// depends on smd_pkg, sorted_merge_with_deletes_unit and smd_merge_checker

module tb_sorted_merge_with_deletes_unit;
  import smd_pkg::*;

  localparam int ID_W    = ID_WIDTH_DEF;
  localparam int IN_W    = 4 + 4 * ID_W;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 4 + ID_W + 1 + 3 + COUNT_W + 2 * ID_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 430;
  // register index sits in paddr[3]; registers are 64 bits, so 8 bytes apart
  localparam logic [CFG_ADDR_W-1:0] RANGE_BASE_ADDR = REG_RANGE_BASE << 3;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [ID_W-1:0] SPAN_STEP = {{(ID_W-SPAN_W-1){1'b0}}, 1'b1, {SPAN_W{1'b0}}};

  // same layout as in_tdata, base_valid at bit 0
  typedef struct packed {
    logic [ID_W-1:0] upd_del_id;
    logic            upd_del_valid;
    logic [ID_W-1:0] base_del_id;
    logic            base_del_valid;
    logic [ID_W-1:0] upd_id;
    logic            upd_valid;
    logic [ID_W-1:0] base_id;
    logic            base_valid;
  } merge_heads_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_TW-1:0]      in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_TW-1:0]     out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fails;
  int pending;
  int n_cycles = 0;
  int n_sent = 0;
  int n_settings = 0;

  // idling knobs: percent of cycles each side holds off; calm marks a stretch
  // where neither side idles
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit calm = 1'b1;

  sorted_merge_with_deletes_unit #(.ID_WIDTH(ID_W)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  smd_merge_checker #(.ID_W(ID_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fails       (fails),
    .pending     (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side backpressure, changed on the falling edge like every input
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic merge_heads_t make_heads(
    logic bv, logic [ID_W-1:0] bid, logic uv, logic [ID_W-1:0] uid,
    logic bdv, logic [ID_W-1:0] bdid, logic udv, logic [ID_W-1:0] udid);
    merge_heads_t h;
    h.base_valid     = bv;
    h.base_id        = bid;
    h.upd_valid      = uv;
    h.upd_id         = uid;
    h.base_del_valid = bdv;
    h.base_del_id    = bdid;
    h.upd_del_valid  = udv;
    h.upd_del_id     = udid;
    return h;
  endfunction

  // fully random heads; delete heads sometimes copy their row so the
  // equality branches show up in the noise too
  function automatic merge_heads_t random_heads();
    merge_heads_t h;
    h = make_heads(1'($urandom_range(1)), {$urandom, $urandom}, 1'($urandom_range(1)),
                   {$urandom, $urandom}, 1'($urandom_range(1)), {$urandom, $urandom},
                   1'($urandom_range(1)), {$urandom, $urandom});
    if ($urandom_range(3) == 0)
      h.base_del_id = h.base_id;
    if ($urandom_range(3) == 0)
      h.upd_del_id = h.upd_id;
    return h;
  endfunction

  // present one item at the falling edge and hold it until the handshake;
  // valid is only dropped when the sender decides to idle
  task automatic send_heads(input merge_heads_t h);
    @(negedge clk);
    while (!calm && $urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {{(IN_TW-IN_W){1'b0}}, h};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // stop sending and hold off until every result item has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= RANGE_BASE_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // write range_base_id with the block idle, then read it back for the checker
  task automatic set_range_base(input logic [ID_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
    n_settings++;
  endtask

  // random merge traffic around one range base: four monotone cursors walk
  // upward from just above the base, so most steps are legal merges with
  // ties, deletes catching up and repeated ids; a share is broken on purpose
  // (cursor stepping back, ids below the base or past the span) and the rest
  // is raw noise
  task automatic run_merge_phase(input int n_items, input int snd_pct, input int rcv_pct,
                                 input logic [ID_W-1:0] base);
    logic [ID_W-1:0] cur [4];   // base row, update row, base delete, update delete
    merge_heads_t h;
    int kind;
    set_range_base(base);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int k = 0; k < 4; k++)
      cur[k] = base + 16 + $urandom_range(3);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0)
        calm = ($urandom_range(3) == 0);
      // sender hold-off until the pipe is empty, once per phase
      if (i == n_items / 2)
        wait_drained();
      for (int k = 0; k < 4; k++)
        if ($urandom_range(1))
          cur[k] += $urandom_range(2);
      // pull delete streams back next to their rows now and then
      if ($urandom_range(7) == 0)
        cur[2] = cur[0] + $urandom_range(4);
      if ($urandom_range(7) == 0)
        cur[3] = cur[1] + $urandom_range(4);
      h = make_heads($urandom_range(99) < 92, cur[0], $urandom_range(99) < 92, cur[1],
                     $urandom_range(99) < 75, cur[2], $urandom_range(99) < 75, cur[3]);
      kind = $urandom_range(99);
      if (kind >= 86) begin
        h = random_heads();
      end else if (kind >= 74) begin
        case ($urandom_range(3))
          0: cur[$urandom_range(3)] -= $urandom_range(8, 1);
          1: h.base_id = base - 1 - $urandom_range(15);
          2: h.upd_id = base + SPAN_STEP + $urandom_range(15);
          default: begin
            h.base_del_id = h.base_id;
            h.upd_del_id  = h.upd_id;
          end
        endcase
      end
      send_heads(h);
    end
    calm = 1'b1;
  endtask

  initial begin
    logic [ID_W-1:0] rb;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed steps, base at zero, no idling
    set_range_base('0);
    // both rows exhausted, delete heads ignored
    send_heads(make_heads(0, ID_MAX, 0, ID_MAX, 1, '0, 1, '0));
    // base delete head behind its row
    send_heads(make_heads(1, 10, 0, 0, 1, 3, 0, 0));
    // update delete head behind its row
    send_heads(make_heads(0, 0, 1, 10, 0, 0, 1, 4));
    // both delete heads behind
    send_heads(make_heads(1, 10, 1, 12, 1, 2, 1, 5));
    // base stream gone, its delete head is ignored: first emit from update
    send_heads(make_heads(0, 0, 1, 10, 1, 0, 0, 0));
    // base row dropped by its delete
    send_heads(make_heads(1, 20, 1, 25, 1, 20, 0, 0));
    // update row also deleted
    send_heads(make_heads(1, 30, 1, 25, 0, 0, 1, 25));
    // lower id from the base stream
    send_heads(make_heads(1, 20, 1, 30, 0, 0, 0, 0));
    // tie, update wins and both advance
    send_heads(make_heads(1, 30, 1, 30, 0, 0, 0, 0));
    send_heads(make_heads(1, 31, 0, 0, 0, 0, 0, 0));
    // same id again: not increasing
    send_heads(make_heads(1, 31, 0, 0, 0, 0, 0, 0));
    // one past the 32-bit span, then exactly at its top
    send_heads(make_heads(1, SPAN_STEP, 0, 0, 0, 0, 0, 0));
    send_heads(make_heads(1, SPAN_STEP - 1, 0, 0, 0, 0, 0, 0));
    // id zero after emits
    send_heads(make_heads(0, 0, 1, 0, 0, 0, 0, 0));

    rb = SPAN_STEP;
    set_range_base(rb);
    // below the range base
    send_heads(make_heads(1, 5, 0, 0, 0, 0, 0, 0));
    // exactly the range base
    send_heads(make_heads(1, rb, 1, rb + 4, 0, 0, 0, 0));
    // update past the span
    send_heads(make_heads(0, 0, 1, rb + SPAN_STEP, 0, 0, 0, 0));
    // skipping a delete head wins over an update conflict
    send_heads(make_heads(1, rb + 8, 1, rb + 8, 1, rb + 1, 1, rb + 8));
    // base deletion wins over an update conflict
    send_heads(make_heads(1, rb + 8, 1, rb + 9, 1, rb + 8, 1, rb + 9));

    run_merge_phase(PHASE_ITEMS, 21, 60, rb);
    run_merge_phase(PHASE_ITEMS, 60, 21, {1'b1, {(ID_W-1){1'b0}}});
    run_merge_phase(PHASE_ITEMS, 0, 0, ~SPAN_STEP + 1);

    // top of the id space: only the all-ones id fits
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_range_base(ID_MAX);
    send_heads(make_heads(1, ID_MAX, 0, 0, 0, 0, 0, 0));
    send_heads(make_heads(0, 0, 1, ID_MAX, 0, 0, 0, 0));
    send_heads(make_heads(1, ID_MAX - 1, 0, 0, 1, ID_MAX, 0, 0));
    send_heads(make_heads(0, ID_MAX, 0, ID_MAX, 1, ID_MAX, 1, ID_MAX));

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    $display("covered %0d merge steps over %0d range base settings, zero to all ones",
             n_sent, n_settings);
    $display("stalls: sender and receiver idling both ways, one drain per random phase");
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
